// ----- design/expiring_indexed_fifo_unit_assert.svh -----
// ---------------------------------------------------------------------------
// expiring_indexed_fifo_unit_assert.svh
// Assertion macros used by the expiring indexed FIFO unit.
// ---------------------------------------------------------------------------
`ifndef EXPIRING_INDEXED_FIFO_UNIT_ASSERT_SVH
`define EXPIRING_INDEXED_FIFO_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define EIF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eif assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define EIF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eif assertion failed");

`endif

// ----- design/eif_pkg.sv -----
// ---------------------------------------------------------------------------
// eif_pkg
// Types, sizes and codes of the expiring indexed FIFO.
// ---------------------------------------------------------------------------
`default_nettype none

package eif_pkg;

    // Storage sizes
    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int SLOT_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W        = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int SEQ_W    = 31;
    localparam int TIME_W   = 48;
    localparam int LIFE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd15000;
    localparam logic [SEQ_W-1:0]  SEQ_MAX        = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_EXPIRE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUST = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [WORD_W-1:0]        payload;
        logic signed [WORD_W-1:0] pick_index;
        logic [TIME_W-1:0]        now_ms;
    } eif_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data_out;
        logic [SEQ_W-1:0]    entry_index;
        logic [OCC_W-1:0]    occupancy;
    } eif_result_t;

    // One stored entry
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [TIME_W-1:0]       expiry;
    } eif_entry_t;

    // Per-cell control
    typedef struct packed {
        logic shift;
        logic load;
    } eif_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/eif_cell.sv -----
// ---------------------------------------------------------------------------
// eif_cell
// One FIFO cell: takes its upstream neighbor's entry on a shift, or a new
// entry on a load, else holds.
// ---------------------------------------------------------------------------
`default_nettype none

module eif_cell
    import eif_pkg::*;
(
    input  wire logic           clk,
    input  wire eif_cell_ctrl_t ctrl,
    input  wire eif_entry_t     upstream,
    input  wire eif_entry_t     load_data,
    output eif_entry_t          entry
);

    eif_entry_t entry_reg;

    // Shift from neighbor, load new entry, or hold
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            entry_reg <= upstream;
        end
        else if (ctrl.load)
        begin
            entry_reg <= load_data;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ----- design/expiring_indexed_fifo_unit.sv -----
// ---------------------------------------------------------------------------
// expiring_indexed_fifo_unit
// Queue of message handles with sequence indexes and expiry times, held in
// a row of cells with the oldest entry in cell 0.
// ---------------------------------------------------------------------------
//  channel | signals                      | transfer
//  --------+------------------------------+----------------------------------
//  command | start, busy, cmd             | start & !busy
//  result  | result_valid, result         | one-cycle strobe, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_data | cfg_valid & cfg_ready
//
//  Put, get and pick: command registered, then executed, with the result
//  strobed in the following cycle (a new command may start then).
//  Expire drops expired head entries: the chain shifts one cell per cycle
//  while the head entry has expired.
//  Reset clears the count and sequence counter and reloads the lifetime
//  with 15000; cells are not reset.
//  The receiver cannot stall results.
// ---------------------------------------------------------------------------
`default_nettype none
`include "expiring_indexed_fifo_unit_assert.svh"

module expiring_indexed_fifo_unit
    import eif_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire eif_cmd_t          cmd,
    output logic                   result_valid,
    output eif_result_t            result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [LIFE_W-1:0] cfg_data
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0]        state_reg, state_next;
    eif_cmd_t          cmd_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [LIFE_W-1:0] life_reg;
    logic              done_reg, done_next;
    eif_result_t       result_reg, result_next;

    eif_entry_t        cells [DEPTH];
    eif_cell_ctrl_t    ctrls [DEPTH];
    eif_entry_t        new_entry;
    logic              shift_all;
    logic              put_go;

    logic [TIME_W:0]   exp_sum;
    logic [SEQ_W-1:0]  first_idx;
    logic [SEQ_W-1:0]  last_idx;
    logic [SEQ_W-1:0]  want_idx;
    logic [SEQ_W-1:0]  pick_idx;
    logic [SEQ_W-1:0]  pick_off;
    eif_entry_t        pick_entry;

    // Cell row: cell i takes cell i+1 on a shift; last cell refills itself
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        eif_entry_t up;
        if (i == DEPTH - 1)
        begin : g_last
            assign up = cells[i];
        end
        else
        begin : g_mid
            assign up = cells[i+1];
        end
        assign ctrls[i].shift = shift_all;
        assign ctrls[i].load  = put_go && (count_reg == CNT_W'(i));
        eif_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrls[i]),
            .upstream  (up),
            .load_data (new_entry),
            .entry     (cells[i])
        );
    end

    // Build new entry with saturated expiry
    assign exp_sum           = {1'b0, cmd_reg.now_ms} + (TIME_W+1)'(life_reg);
    assign new_entry.payload = PAYLOAD_BITS'(cmd_reg.payload);
    assign new_entry.expiry  = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

    // Index window and pick location
    assign first_idx  = seq_reg - SEQ_W'(count_reg);
    assign last_idx   = seq_reg - SEQ_W'(1);
    assign want_idx   = cmd_reg.pick_index[SEQ_W-1:0];
    assign pick_idx   = (cmd_reg.pick_index[WORD_W-1] || (want_idx < first_idx))
                        ? first_idx : want_idx;
    assign pick_off   = pick_idx - first_idx;
    assign pick_entry = cells[pick_off[SLOT_W-1:0]];

    // Execute the registered command
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        seq_next    = seq_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        shift_all   = 1'b0;
        put_go      = 1'b0;
        if (state_reg == S_EXEC)
        begin
            result_next.status      = ST_OK;
            result_next.data_out    = '0;
            result_next.entry_index = '0;
            done_next               = 1'b1;
            state_next              = S_IDLE;
            case (cmd_reg.op)
                OP_PUT:
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        result_next.status = ST_FULL;
                    end
                    else if (seq_reg == SEQ_MAX)
                    begin
                        result_next.status = ST_EXHAUST;
                    end
                    else
                    begin
                        put_go                  = 1'b1;
                        result_next.entry_index = seq_reg;
                        seq_next                = seq_reg + SEQ_W'(1);
                        count_next              = count_reg + CNT_W'(1);
                    end
                end
                OP_GET:
                begin
                    if (count_reg == '0)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        result_next.data_out    = WORD_W'(cells[0].payload);
                        result_next.entry_index = first_idx;
                        shift_all               = 1'b1;
                        count_next              = count_reg - CNT_W'(1);
                    end
                end
                OP_PICK:
                begin
                    if (count_reg == '0)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else if (!cmd_reg.pick_index[WORD_W-1] && (want_idx > last_idx))
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        result_next.data_out    = WORD_W'(pick_entry.payload);
                        result_next.entry_index = pick_idx;
                    end
                end
                default:
                begin
                    // Drop one expired head entry per cycle
                    if ((count_reg != '0) && (cells[0].expiry <= cmd_reg.now_ms))
                    begin
                        shift_all   = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                        done_next   = 1'b0;
                        state_next  = S_EXEC;
                    end
                end
            endcase
            result_next.occupancy = OCC_W'(count_next);
        end
        else if (start)
        begin
            state_next = S_EXEC;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            seq_reg   <= '0;
            life_reg  <= LIFETIME_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                life_reg <= cfg_data;
            end
        end
    end

    // Capture command and result payload
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        result_reg <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = !busy;
    assign result_valid = done_reg;
    assign result       = result_reg;

    `EIF_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `EIF_ASSERT_SAME(a_strobe_idle, result_valid, !busy)
    `EIF_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `EIF_ASSERT_NEXT(a_strobe_once, result_valid, !result_valid)

endmodule

`default_nettype wire
